/* rtl/mtet_pkg.sv */
// Package for the multi-turn encoder tracker.
// Command codes, register indexes, reset values and shared types. No dependencies.
package mtet_pkg;

    localparam int TURN_COUNTS_DEF = 65536;

    localparam int CMD_W    = 3;
    localparam int TIME_W   = 32;
    localparam int PAY_W    = 64;
    localparam int POS_W    = 32;
    localparam int SINGLE_W = 16;
    localparam int MS_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_POS_FRAME = 3'd0,
        CMD_VEL_FRAME = 3'd1,
        CMD_POLL      = 3'd2,
        CMD_READ      = 3'd3,
        CMD_WRITE_OFS = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE  = 2'd0,
        REG_STALE   = 2'd1,
        REG_HOLDOFF = 2'd2
    } t_reg_idx;

    localparam logic            ENABLE_RST  = 1'b1;
    localparam logic [MS_W-1:0] STALE_RST   = 16'd1000;
    localparam logic [MS_W-1:0] HOLDOFF_RST = 16'd500;

    // per-item strobes toward the timing/poll unit
    typedef struct packed {
        logic pos_frame;
        logic vel_frame;
        logic poll;
    } t_evt;

endpackage

/* rtl/mtet_in_if.sv */
// Input channel of the encoder tracker: valid/ready plus one command item.
// Depends on mtet_pkg.
interface mtet_in_if;
    import mtet_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [TIME_W-1:0]        now_ms;
    logic [PAY_W-1:0]         frame_payload;
    logic signed [POS_W-1:0]  new_position;

    modport source (output valid, command, now_ms, frame_payload, new_position,
                    input ready);
    modport sink   (input valid, command, now_ms, frame_payload, new_position,
                    output ready);
endinterface

/* rtl/mtet_out_if.sv */
// Result channel of the encoder tracker: valid/ready plus one result item.
// Depends on mtet_pkg.
interface mtet_out_if;
    import mtet_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  position;
    logic                     request_sent;
    logic [POS_W-1:0]         error_count;

    modport source (output valid, position, request_sent, error_count, input ready);
    modport sink   (input valid, position, request_sent, error_count, output ready);
endinterface

/* rtl/mtet_unwrap.sv */
// Turn unwrapping: tracks last single-turn value and the signed turn counter,
// and keeps the 32-bit multi-turn count. Depends on mtet_pkg.
module mtet_unwrap #(
    parameter int TURN_COUNTS = mtet_pkg::TURN_COUNTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [mtet_pkg::SINGLE_W-1:0]  i_single,
    output logic [mtet_pkg::POS_W-1:0]     o_turn_count
);
    import mtet_pkg::*;

    localparam logic [SINGLE_W:0] HI_THR = (SINGLE_W+1)'((TURN_COUNTS * 3) / 4);
    localparam logic [SINGLE_W:0] LO_THR = (SINGLE_W+1)'((TURN_COUNTS * 1) / 4);
    localparam logic [POS_W-1:0]  TURN_SZ = POS_W'(TURN_COUNTS);

    logic [SINGLE_W-1:0] r_last_single, n_last_single;
    logic [SINGLE_W-1:0] r_turns, n_turns;
    logic                r_first, n_first;
    logic [POS_W-1:0]    r_turn_count, n_turn_count;

    logic [SINGLE_W:0]   last_x, cur_x;
    logic [POS_W-1:0]    turns_ext;

    always_comb begin
        last_x        = {1'b0, r_last_single};
        cur_x         = {1'b0, i_single};
        n_turns       = r_turns;
        n_last_single = r_last_single;
        n_first       = r_first;
        if (i_take && !r_first) begin
            if (last_x > HI_THR && cur_x < LO_THR) begin
                n_turns = r_turns + 1'b1;
            end else if (last_x < LO_THR && cur_x > HI_THR) begin
                n_turns = r_turns - 1'b1;
            end
        end
        if (i_take) begin
            n_first       = 1'b0;
            n_last_single = i_single;
        end
        turns_ext    = {{(POS_W-SINGLE_W){n_turns[SINGLE_W-1]}}, n_turns};
        n_turn_count = r_turn_count;
        if (i_take) begin
            // product wraps modulo 2^32 like the count itself
            n_turn_count = turns_ext * TURN_SZ + {{(POS_W-SINGLE_W){1'b0}}, i_single};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_single <= '0;
            r_turns       <= '0;
            r_first       <= 1'b1;
            r_turn_count  <= '0;
        end else begin
            r_last_single <= n_last_single;
            r_turns       <= n_turns;
            r_first       <= n_first;
            r_turn_count  <= n_turn_count;
        end
    end

    assign o_turn_count = r_turn_count;
endmodule

/* rtl/mtet_poll.sv */
// Frame age tracking and poll handling: frame timestamps, stale error counter,
// position request decision. Depends on mtet_pkg.
module mtet_poll (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtet_pkg::t_evt                i_evt,
    input  logic [mtet_pkg::TIME_W-1:0]   i_now,
    input  logic [mtet_pkg::MS_W-1:0]     i_stale_ms,
    input  logic [mtet_pkg::MS_W-1:0]     i_holdoff_ms,
    output logic                          o_req,
    output logic [mtet_pkg::POS_W-1:0]    o_errors
);
    import mtet_pkg::*;

    logic [TIME_W-1:0] r_pos_time, n_pos_time;
    logic [TIME_W-1:0] r_vel_time, n_vel_time;
    logic [POS_W-1:0]  r_errors, n_errors;
    logic [TIME_W-1:0] age_p, age_v, stale_x, hold_x;

    always_comb begin
        age_p      = i_now - r_pos_time;
        age_v      = i_now - r_vel_time;
        stale_x    = {{(TIME_W-MS_W){1'b0}}, i_stale_ms};
        hold_x     = {{(TIME_W-MS_W){1'b0}}, i_holdoff_ms};
        n_pos_time = i_evt.pos_frame ? i_now : r_pos_time;
        n_vel_time = i_evt.vel_frame ? i_now : r_vel_time;
        n_errors   = r_errors;
        o_req      = 1'b0;
        if (i_evt.poll) begin
            if (age_p > stale_x && age_v > stale_x) begin
                n_errors = r_errors + 1'b1;
            end
            o_req = !(age_v < hold_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_time <= '0;
            r_vel_time <= '0;
            r_errors   <= '0;
        end else begin
            r_pos_time <= n_pos_time;
            r_vel_time <= n_vel_time;
            r_errors   <= n_errors;
        end
    end

    // value after this item, as reported with its result
    assign o_errors = n_errors;
endmodule

/* rtl/multi_turn_encoder_tracker.sv */
// Multi-turn encoder tracker. Takes one command per cycle (position frame,
// velocity frame, poll, read, offset write) as long as the result side keeps
// taking, and returns exactly one result per command, through the input
// register and then the result register. Throughput is one item per clock;
// the input register lets a new item enter while a finished result waits in
// the result register. Configuration writes are taken at any time on the
// write port and should only be issued while no item is in flight.
// Depends on mtet_pkg, mtet_in_if, mtet_out_if, mtet_unwrap, mtet_poll.
module multi_turn_encoder_tracker #(
    parameter int TURN_COUNTS = mtet_pkg::TURN_COUNTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mtet_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mtet_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mtet_in_if.sink                           i_in,
    mtet_out_if.source                        o_out
);
    import mtet_pkg::*;

    // configuration
    logic            r_enable;
    logic [MS_W-1:0] r_stale_ms, r_holdoff_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= ENABLE_RST;
            r_stale_ms   <= STALE_RST;
            r_holdoff_ms <= HOLDOFF_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ENABLE:  r_enable     <= i_cfg_data[0];
                REG_STALE:   r_stale_ms   <= i_cfg_data;
                REG_HOLDOFF: r_holdoff_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic                    r_in_valid;
    logic [CMD_W-1:0]        r_cmd;
    logic [TIME_W-1:0]       r_now;
    logic [PAY_W-1:0]        r_pay;
    logic [POS_W-1:0]        r_newpos;
    logic                    in_xfer, advance;

    assign advance    = r_in_valid && (!o_out.valid || o_out.ready);
    assign i_in.ready = !r_in_valid || !o_out.valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd    <= i_in.command;
            r_now    <= i_in.now_ms;
            r_pay    <= i_in.frame_payload;
            r_newpos <= i_in.new_position;
        end
    end

    // decode
    t_evt                evt;
    logic                take, do_read, do_write;
    logic [SINGLE_W-1:0] single;

    always_comb begin
        evt      = '0;
        do_read  = 1'b0;
        do_write = 1'b0;
        single   = r_pay[16 +: SINGLE_W];
        unique case (t_cmd'(r_cmd))
            CMD_POS_FRAME: evt.pos_frame = advance;
            CMD_VEL_FRAME: begin
                evt.vel_frame = advance;
                single        = r_pay[48 +: SINGLE_W];
            end
            CMD_POLL:      evt.poll = advance;
            CMD_READ:      do_read  = r_enable;
            CMD_WRITE_OFS: do_write = advance && r_enable;
            default: ;
        endcase
        take = evt.pos_frame || evt.vel_frame;
    end

    logic [POS_W-1:0] turn_count, errors_nxt;
    logic             req;

    mtet_unwrap #(
        .TURN_COUNTS (TURN_COUNTS)
    ) u_unwrap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_single     (single),
        .o_turn_count (turn_count)
    );

    mtet_poll u_poll (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (evt),
        .i_now        (r_now),
        .i_stale_ms   (r_stale_ms),
        .i_holdoff_ms (r_holdoff_ms),
        .o_req        (req),
        .o_errors     (errors_nxt)
    );

    // offset
    logic [POS_W-1:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (do_write) begin
            r_offset <= r_newpos - turn_count;
        end
    end

    // result register
    logic             r_out_valid;
    logic [POS_W-1:0] r_pos, r_err;
    logic             r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pos <= do_read ? (turn_count + r_offset) : '0;
            r_req <= req;
            r_err <= errors_nxt;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.position     = r_pos;
    assign o_out.request_sent = r_req;
    assign o_out.error_count  = r_err;
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for multi_turn_encoder_tracker: a directed walk across the turn boundaries,
// then random command streams under several register settings. Every result is checked.
// Depends on mtet_pkg, mtet_in_if, mtet_out_if and the tracker RTL.
module testbench;
    import mtet_pkg::*;

    localparam int TURN_SIZE   = TURN_COUNTS_DEF;
    localparam int QUARTER     = TURN_SIZE / 4;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [SINGLE_W-1:0] ANGLE_MARKS [8] = '{
        16'(0), 16'(QUARTER - 1), 16'(QUARTER), 16'(QUARTER + 1),
        16'(3 * QUARTER - 1), 16'(3 * QUARTER), 16'(3 * QUARTER + 1), 16'(TURN_SIZE - 1)
    };
    localparam logic [SINGLE_W-1:0] DIRECTED_WALK [8] = '{
        16'hC000, 16'h0000, 16'hC001, 16'h3FFF, 16'hFFFF, 16'h4000, 16'h0000, 16'hC001
    };

    typedef struct {
        logic [POS_W-1:0] position;
        logic             request_sent;
        logic [POS_W-1:0] error_count;
    } t_reading;

    // Tracks turns, offset and frame ages, and holds the readings still owed by the block.
    class t_turn_tracker_scoreboard;
        bit                enable;
        bit [MS_W-1:0]     stale_ms;
        bit [MS_W-1:0]     holdoff_ms;
        bit [SINGLE_W-1:0] last_single;
        bit [15:0]         turns;
        bit                first_frame;
        bit [31:0]         turn_count;
        bit [31:0]         offset;
        bit [31:0]         pos_seen_ms;
        bit [31:0]         vel_seen_ms;
        bit [31:0]         stale_polls;
        t_reading          expected_readings[$];
        int                mismatches;

        function new();
            enable      = ENABLE_RST;
            stale_ms    = STALE_RST;
            holdoff_ms  = HOLDOFF_RST;
            last_single = '0;
            turns       = '0;
            first_frame = 1'b1;
            turn_count  = '0;
            offset      = '0;
            pos_seen_ms = '0;
            vel_seen_ms = '0;
            stale_polls = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(t_reg_idx idx, bit [CFG_DATA_W-1:0] value);
            case (idx)
                REG_ENABLE:  enable = value[0];
                REG_STALE:   stale_ms = value;
                REG_HOLDOFF: holdoff_ms = value;
                default: ;
            endcase
        endfunction

        function void take_single(bit [SINGLE_W-1:0] single);
            bit [31:0] turns_ext;
            if (!first_frame) begin
                if (last_single > 3 * QUARTER && single < QUARTER) turns = turns + 16'd1;
                if (last_single < QUARTER && single > 3 * QUARTER) turns = turns - 16'd1;
            end
            first_frame = 1'b0;
            last_single = single;
            turns_ext   = {{16{turns[15]}}, turns};
            turn_count  = 32'(single) + turns_ext * 32'(TURN_SIZE);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [31:0] now,
                                   logic [PAY_W-1:0] pay, logic [31:0] new_pos);
            t_reading  r;
            bit [31:0] age_p;
            bit [31:0] age_v;
            r.position     = '0;
            r.request_sent = 1'b0;
            case (cmd)
                CMD_POS_FRAME: begin
                    pos_seen_ms = now;
                    take_single(pay[31:16]);
                end
                CMD_VEL_FRAME: begin
                    vel_seen_ms = now;
                    take_single(pay[63:48]);
                end
                CMD_POLL: begin
                    age_p = now - pos_seen_ms;
                    age_v = now - vel_seen_ms;
                    if (age_p > stale_ms && age_v > stale_ms) stale_polls = stale_polls + 1;
                    r.request_sent = !(age_v < holdoff_ms);
                end
                CMD_READ: begin
                    if (enable) r.position = turn_count + offset;
                end
                CMD_WRITE_OFS: begin
                    if (enable) offset = new_pos - turn_count;
                end
                default: ;
            endcase
            r.error_count = stale_polls;
            expected_readings.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_reading(logic [POS_W-1:0] pos, logic req, logic [POS_W-1:0] errs);
            t_reading e;
            if (expected_readings.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
                return;
            end
            e = expected_readings.pop_front();
            if (pos !== e.position)
                report_mismatch($sformatf("position %h, expected %h", pos, e.position));
            if (req !== e.request_sent)
                report_mismatch($sformatf("request_sent %b, expected %b", req, e.request_sent));
            if (errs !== e.error_count)
                report_mismatch($sformatf("error_count %h, expected %h", errs, e.error_count));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mtet_in_if  in_ch();
    mtet_out_if out_ch();

    multi_turn_encoder_tracker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_turn_tracker_scoreboard sb = new();

    int                gap_pct     = 0;
    int                stall_pct   = 0;
    bit                idle_off    = 1'b0;
    int                cycle_count = 0;
    logic [31:0]       ms_clock;
    logic [SINGLE_W-1:0] angle;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // results are checked before the same edge's input is noted; latency keeps them apart
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_reading(out_ch.position, out_ch.request_sent, out_ch.error_count);
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                sb.note_command(in_ch.command, in_ch.now_ms, in_ch.frame_payload,
                                in_ch.new_position);
        end
    end

    // result side: random stall bursts
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!idle_off && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [PAY_W-1:0] frame_word(bit vel, logic [SINGLE_W-1:0] single,
                                                    logic [PAY_W-1:0] fill);
        logic [PAY_W-1:0] w;
        w = fill;
        if (vel) w[63:48] = single;
        else     w[31:16] = single;
        return w;
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [31:0] now,
                            input logic [PAY_W-1:0] pay, input logic [31:0] new_pos);
        if (!idle_off && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.command       <= cmd;
        in_ch.now_ms        <= now;
        in_ch.frame_payload <= pay;
        in_ch.new_position  <= new_pos;
        in_ch.valid         <= 1'b1;
        ms_clock = now;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    // hold the input side until every owed reading has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        // let the last transfer be noted before looking at the queue
        @(posedge i_clk);
        while (sb.expected_readings.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input bit en, input logic [MS_W-1:0] stale,
                                  input logic [MS_W-1:0] holdoff);
        settle();
        // upper bits of the enable word are junk on purpose
        write_reg(REG_ENABLE, {15'($urandom_range(0, 32767)), en});
        write_reg(REG_STALE, stale);
        write_reg(REG_HOLDOFF, holdoff);
    endtask

    task automatic directed_items();
        send_cmd(CMD_READ, 32'd0, '1, '1);
        // holdoff and stale thresholds against the reset timestamps
        send_cmd(CMD_POLL, 32'd499, '0, '0);
        send_cmd(CMD_POLL, 32'd500, '1, '1);
        send_cmd(CMD_POLL, 32'd1000, '0, '0);
        send_cmd(CMD_POLL, 32'd1001, '1, '1);
        send_cmd(CMD_POLL, 32'hFFFF_FFFF, '0, '0);
        // first frame jumps low to high without losing a turn
        send_cmd(CMD_POS_FRAME, 32'd2000, '1, '0);
        send_cmd(CMD_VEL_FRAME, 32'd2010, frame_word(1'b1, 16'h0000, '1), '1);
        send_cmd(CMD_READ, 32'd2020, '0, '0);
        for (int k = 0; k < 8; k++)
            send_cmd((k % 2) ? CMD_VEL_FRAME : CMD_POS_FRAME, 32'(2030 + 10 * k),
                     frame_word(1'(k % 2), DIRECTED_WALK[k], (k % 4 < 2) ? 64'd0 : ~64'd0),
                     $urandom);
        send_cmd(CMD_READ, 32'd2200, '1, '1);
        send_cmd(CMD_WRITE_OFS, 32'd2210, '0, 32'h7FFF_FFFF);
        send_cmd(CMD_READ, 32'd2220, '0, '0);
        send_cmd(CMD_WRITE_OFS, 32'd2230, '1, 32'h8000_0000);
        send_cmd(CMD_READ, 32'd2240, '1, '1);
        for (int c = CMD_WRITE_OFS + 1; c < 2 ** CMD_W; c++)
            send_cmd(CMD_W'(c), $urandom, {$urandom, $urandom}, $urandom);
    endtask

    task automatic random_items(input int count);
        int                  pick;
        int                  r;
        logic [CMD_W-1:0]    cmd;
        logic [31:0]         now;
        logic [31:0]         new_pos;
        logic [PAY_W-1:0]    pay;
        logic [31:0]         base;
        logic [MS_W-1:0]     span;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 33)      cmd = CMD_POS_FRAME;
            else if (pick < 55) cmd = CMD_VEL_FRAME;
            else if (pick < 75) cmd = CMD_POLL;
            else if (pick < 87) cmd = CMD_READ;
            else if (pick < 95) cmd = CMD_WRITE_OFS;
            else                cmd = CMD_W'($urandom_range(CMD_WRITE_OFS + 1, 2 ** CMD_W - 1));

            r = $urandom_range(0, 99);
            if (cmd == CMD_POLL && r < 50) begin
                // land right around a stale or holdoff threshold
                base = $urandom_range(0, 1) ? sb.pos_seen_ms : sb.vel_seen_ms;
                span = $urandom_range(0, 1) ? sb.stale_ms : sb.holdoff_ms;
                now  = base + span + $urandom_range(0, 4) - 2;
            end else if (r < 70) now = ms_clock + $urandom_range(0, 40);
            else if (r < 90)     now = ms_clock + $urandom_range(0, 2500);
            else if (r < 97)     now = ms_clock + $urandom_range(0, 200000);
            else                 now = $urandom;

            pay = {$urandom, $urandom};
            if (cmd == CMD_POS_FRAME || cmd == CMD_VEL_FRAME) begin
                r = $urandom_range(0, 99);
                if (r < 80)      angle = angle + 16'($urandom_range(0, 18000)) - 16'd9000;
                else if (r < 90) angle = ANGLE_MARKS[$urandom_range(0, 7)];
                else             angle = 16'($urandom);
                pay = frame_word(cmd == CMD_VEL_FRAME, angle, pay);
            end

            r = $urandom_range(0, 99);
            if (r < 3)       new_pos = 32'h7FFF_FFFF;
            else if (r < 6)  new_pos = 32'h8000_0000;
            else if (r < 8)  new_pos = '0;
            else if (r < 10) new_pos = '1;
            else             new_pos = $urandom;

            send_cmd(cmd, now, pay, new_pos);
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.command       <= '0;
        in_ch.now_ms        <= '0;
        in_ch.frame_payload <= '0;
        in_ch.new_position  <= '0;
        ms_clock = '0;
        angle    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();

        apply_settings(1'b1, 16'd0, 16'd0);
        gap_pct = 8; stall_pct = 6;
        random_items(130);

        apply_settings(1'b0, 16'hFFFF, 16'hFFFF);
        gap_pct = 20; stall_pct = 3;
        random_items(130);

        apply_settings(1'b1, 16'hFFFF, 16'd0);
        gap_pct = 0; stall_pct = 0;
        random_items(130);

        apply_settings(1'b1, 16'd0, 16'hFFFF);
        gap_pct = 3; stall_pct = 12;
        random_items(130);

        apply_settings(1'b1, 16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)));
        gap_pct = 10; stall_pct = 10;
        random_items(140);

        apply_settings(1'b1, 16'($urandom), 16'($urandom_range(1, 3000)));
        gap_pct = 5; stall_pct = 5;
        random_items(140);

        apply_settings(1'b1, STALE_RST, HOLDOFF_RST);
        idle_off = 1'b1;
        random_items(150);

        settle();
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
